// ----- design/bmp24_stream_pixel_extractor_core_macros.svh -----
// Assertion macros for the BMP pixel extractor core.
// Included by the top level; needs nothing else.
`ifndef BMP24_STREAM_PIXEL_EXTRACTOR_CORE_MACROS_SVH
`define BMP24_STREAM_PIXEL_EXTRACTOR_CORE_MACROS_SVH

// same-cycle implication
`define BMP24_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BMP24_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/bmp24_pkg.sv -----
// Types and constants shared by the BMP pixel extractor modules.
// No dependencies.
`timescale 1ns / 1ps

package bmp24_pkg;

   localparam logic [5:0] HDR_LEN    = 6'd54;
   localparam logic [5:0] WIDTH_POS  = 6'd18;
   localparam logic [5:0] HEIGHT_POS = 6'd22;
   localparam int         DIM_FIELD_BYTES = 4;
   localparam int         HDR_FIELD_BITS  = 8 * DIM_FIELD_BYTES;

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_PIXELS = 2'd1;
   localparam logic [1:0] PH_PAD    = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   localparam logic [1:0] KIND_PIXEL    = 2'd0;
   localparam logic [1:0] KIND_EMPTY    = 2'd1;
   localparam logic [1:0] KIND_OVERSIZE = 2'd2;

   // blue and green byte slots within a pixel; red is the third byte
   localparam logic [1:0] SLOT_BLUE  = 2'd0;
   localparam logic [1:0] SLOT_GREEN = 2'd1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] row_index;
      logic [15:0] column_index;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        last_pixel;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } push_type;

endpackage

// ----- design/bmp24_parser.sv -----
// Byte parser: header capture, pixel assembly, row padding skip.
// Depends on bmp24_pkg.
`timescale 1ns / 1ps

module bmp24_parser #(
   parameter int DIM_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  bmp24_pkg::req_type req,
   output bmp24_pkg::push_type push
);

   localparam int CNT_EXT = DIM_BITS + 1;
   localparam int HB = bmp24_pkg::HDR_FIELD_BITS;

   logic [1:0]          phase_ff, phase_in, cur_phase;
   logic [5:0]          hdr_ff, hdr_in, cur_hdr;
   logic [HB-1:0]       width_ff, width_in, cur_width;
   logic [HB-1:0]       height_ff, height_in, cur_height;
   logic [DIM_BITS-1:0] row_ff, row_in, cur_row;
   logic [DIM_BITS-1:0] col_ff, col_in, cur_col;
   logic [1:0]          bip_ff, bip_in, cur_bip;
   logic [7:0]          blue_ff, blue_in, cur_blue;
   logic [7:0]          green_ff, green_in, cur_green;
   logic [1:0]          pad_ff, pad_in, cur_pad;

   logic [CNT_EXT-1:0]  col_inc, row_inc;
   logic [1:0]          slot;
   logic                last_col, last_row, oversize, empty;

   always_comb begin
      // a start restarts the parser on this very byte
      if (req.file_start) begin
         cur_phase  = bmp24_pkg::PH_HEADER;
         cur_hdr    = '0;
         cur_width  = '0;
         cur_height = '0;
         cur_row    = '0;
         cur_col    = '0;
         cur_bip    = '0;
         cur_blue   = '0;
         cur_green  = '0;
         cur_pad    = '0;
      end else begin
         cur_phase  = phase_ff;
         cur_hdr    = hdr_ff;
         cur_width  = width_ff;
         cur_height = height_ff;
         cur_row    = row_ff;
         cur_col    = col_ff;
         cur_bip    = bip_ff;
         cur_blue   = blue_ff;
         cur_green  = green_ff;
         cur_pad    = pad_ff;
      end

      phase_in  = cur_phase;
      hdr_in    = cur_hdr;
      width_in  = cur_width;
      height_in = cur_height;
      row_in    = cur_row;
      col_in    = cur_col;
      bip_in    = cur_bip;
      blue_in   = cur_blue;
      green_in  = cur_green;
      pad_in    = cur_pad;

      col_inc  = {1'b0, cur_col} + CNT_EXT'(1);
      row_inc  = {1'b0, cur_row} + CNT_EXT'(1);
      last_col = (col_inc == {1'b0, cur_width[DIM_BITS-1:0]});
      last_row = (row_inc == {1'b0, cur_height[DIM_BITS-1:0]});
      slot     = 2'(cur_hdr - bmp24_pkg::WIDTH_POS);
      oversize = 1'b0;
      empty    = 1'b0;

      push.valid = 1'b0;
      push.data  = '0;

      unique case (cur_phase)
         bmp24_pkg::PH_HEADER: begin
            if (cur_hdr >= bmp24_pkg::WIDTH_POS &&
                cur_hdr < bmp24_pkg::WIDTH_POS + 6'(bmp24_pkg::DIM_FIELD_BYTES)) begin
               slot = 2'(cur_hdr - bmp24_pkg::WIDTH_POS);
               width_in[8*slot +: 8] = req.data_byte;
            end else if (cur_hdr >= bmp24_pkg::HEIGHT_POS &&
                cur_hdr < bmp24_pkg::HEIGHT_POS + 6'(bmp24_pkg::DIM_FIELD_BYTES)) begin
               slot = 2'(cur_hdr - bmp24_pkg::HEIGHT_POS);
               height_in[8*slot +: 8] = req.data_byte;
            end
            if (cur_hdr != bmp24_pkg::HDR_LEN - 6'd1) begin
               hdr_in = cur_hdr + 6'd1;
            end else begin
               hdr_in   = '0;
               oversize = ((width_in >> DIM_BITS) != '0) || ((height_in >> DIM_BITS) != '0);
               empty    = (width_in == '0) || (height_in == '0);
               if (empty || oversize) begin
                  phase_in             = bmp24_pkg::PH_DONE;
                  push.valid           = 1'b1;
                  push.data.kind       = empty ? bmp24_pkg::KIND_EMPTY
                                               : bmp24_pkg::KIND_OVERSIZE;
                  push.data.last_pixel = 1'b1;
               end else begin
                  phase_in = bmp24_pkg::PH_PIXELS;
               end
            end
         end
         bmp24_pkg::PH_PIXELS: begin
            if (cur_bip == bmp24_pkg::SLOT_BLUE) begin
               blue_in = req.data_byte;
               bip_in  = cur_bip + 2'd1;
            end else if (cur_bip == bmp24_pkg::SLOT_GREEN) begin
               green_in = req.data_byte;
               bip_in   = cur_bip + 2'd1;
            end else begin
               bip_in                 = bmp24_pkg::SLOT_BLUE;
               push.valid             = 1'b1;
               push.data.kind         = bmp24_pkg::KIND_PIXEL;
               push.data.red          = req.data_byte;
               push.data.green        = cur_green;
               push.data.blue         = cur_blue;
               push.data.row_index    = 16'(cur_row);
               push.data.column_index = 16'(cur_col);
               push.data.last_pixel   = last_col && last_row;
               if (!last_col) begin
                  col_in = col_inc[DIM_BITS-1:0];
               end else if (last_row) begin
                  phase_in = bmp24_pkg::PH_DONE;
               end else begin
                  col_in = '0;
                  // 3*w bytes per row: padding to a multiple of four is w mod 4
                  if (cur_width[1:0] != 2'd0) begin
                     pad_in   = cur_width[1:0];
                     phase_in = bmp24_pkg::PH_PAD;
                  end else begin
                     row_in = row_inc[DIM_BITS-1:0];
                  end
               end
            end
         end
         bmp24_pkg::PH_PAD: begin
            pad_in = cur_pad - 2'd1;
            if (pad_in == 2'd0) begin
               row_in   = row_inc[DIM_BITS-1:0];
               phase_in = bmp24_pkg::PH_PIXELS;
            end
         end
         bmp24_pkg::PH_DONE: begin
         end
      endcase

      push.data.image_width  = width_in[15:0];
      push.data.image_height = height_in[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= bmp24_pkg::PH_HEADER;
         hdr_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         bip_ff    <= '0;
         blue_ff   <= '0;
         green_ff  <= '0;
         pad_ff    <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         hdr_ff    <= hdr_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         bip_ff    <= bip_in;
         blue_ff   <= blue_in;
         green_ff  <= green_in;
         pad_ff    <= pad_in;
      end
   end

endmodule

// ----- design/bmp24_out_buf.sv -----
// Two-entry result buffer between the parser and the result channel.
// Depends on bmp24_pkg.
`timescale 1ns / 1ps

module bmp24_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  bmp24_pkg::push_type push,
   output logic                full,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bmp24_pkg::rsp_type  rsp_payload
);

   logic [1:0]         count_ff, count_in;
   bmp24_pkg::rsp_type head_ff, head_in, tail_ff, tail_in;
   logic               pop;

   assign full        = (count_ff == 2'd2);
   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_payload = head_ff;
   assign pop         = rsp_valid && !rsp_stall;

   // push is only offered while not full
   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      unique case ({push.valid, pop})
         2'b10: begin
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) begin
               head_in = push.data;
            end else begin
               tail_in = push.data;
            end
         end
         2'b01: begin
            count_in = count_ff - 2'd1;
            head_in  = tail_ff;
         end
         2'b11: begin
            head_in = push.data;
         end
         2'b00: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

// ----- design/bmp24_stream_pixel_extractor_core.sv -----
// Top level of the 24-bit BMP pixel extractor.
// Depends on bmp24_pkg, bmp24_parser, bmp24_out_buf and the macros header.
`timescale 1ns / 1ps

// Takes a 24-bit uncompressed BMP file one byte per transfer, at one byte per
// clock cycle while req_stall is low, and returns one result per pixel (kind
// pixel) or one status result after the 54-byte header (empty or oversize
// image). The parser updates its counters and byte capture in the cycle a byte
// is taken; the result is registered into a two-entry buffer that drives rsp.
// req_stall rises only while both buffer entries hold untaken results. A
// byte with file_start high restarts the parser as header byte 0. Row
// padding is skipped; after the last pixel or a status result, bytes are
// dropped until the next start. DIM_BITS sets the row and column counter
// width and the oversize limit.

`include "bmp24_stream_pixel_extractor_core_macros.svh"

module bmp24_stream_pixel_extractor_core #(
   parameter int DIM_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  bmp24_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output bmp24_pkg::rsp_type rsp_payload
);

   logic                accept;
   logic                full;
   bmp24_pkg::push_type push;
   bmp24_pkg::push_type push_gated;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   always_comb begin
      push_gated       = push;
      push_gated.valid = push.valid && accept;
   end

   bmp24_parser #(
      .DIM_BITS(DIM_BITS)
   ) u_parser (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req_payload),
      .push  (push)
   );

   bmp24_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push_gated),
      .full       (full),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   `BMP24_ASSERT_NOW(a_status_is_last, clock, reset, rsp_valid && rsp_payload.kind != bmp24_pkg::KIND_PIXEL, rsp_payload.last_pixel, "status result without last flag")
   `BMP24_ASSERT_NOW(a_status_zero, clock, reset, rsp_valid && rsp_payload.kind != bmp24_pkg::KIND_PIXEL, rsp_payload.red == 8'd0 && rsp_payload.row_index == 16'd0 && rsp_payload.column_index == 16'd0, "status result carries pixel data")
   `BMP24_ASSERT_NEXT(a_accept_yields_valid, clock, reset, accept && push.valid, rsp_valid, "accepted result not presented")

endmodule
